FILE: design/lkv_pkg.sv
// shared types and codes for the linear key/value table
// item structs, command and status codes, sequencer states; no dependencies
package lkv_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS     = 32;
   localparam int VALUE_BITS   = 32;
   localparam int COUNT_BITS   = 7;

   localparam logic [2:0] CMD_SET        = 3'd0;
   localparam logic [2:0] CMD_REMOVE     = 3'd1;
   localparam logic [2:0] CMD_FIND       = 3'd2;
   localparam logic [2:0] CMD_ITER_START = 3'd3;
   localparam logic [2:0] CMD_ITER_NEXT  = 3'd4;
   localparam logic [2:0] CMD_ITER_DEL   = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_VALUE = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_ZERO_KEY   = 3'd3;
   localparam logic [2:0] ST_NO_ENTRY   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_POS_READ,
      S_POS_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]            command;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic                  found;
      logic [KEY_BITS-1:0]   out_key;
      logic [VALUE_BITS-1:0] out_value;
      logic [COUNT_BITS-1:0] live_count;
   } rsp_type;

endpackage

FILE: design/lkv_slot_ram.sv
// slot storage: one write port, one read port with registered read data
// depends on lkv_pkg for default widths
module lkv_slot_ram import lkv_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = KEY_BITS + VALUE_BITS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/linear_key_value_table_unit.sv
// linear key/value table: append-order slots in a ram, searched one slot per cycle by a
// shared key compare under a small sequencer; depends on lkv_pkg and lkv_slot_ram
// set, remove, find and iterator next scan the slots below the fill mark until a match, one
// ram read per scanned slot, between accept and result; remove at iterator reads and checks
// only its own slot; restart and rejects go straight to the result; one item at a time
// synchronous reset zeroes fill mark and count and parks the iterator; slots are not cleared
module linear_key_value_table_unit import lkv_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   state_type state_ff, state_in;

   logic [2:0]            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] iter_pos_ff, iter_pos_in;
   logic          iter_before_ff, iter_before_in;

   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_pend_ff, rd_pend_in;

   logic [2:0]            res_status_ff, res_status_in;
   logic                  res_found_ff, res_found_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic [KEY_BITS+VALUE_BITS-1:0]   ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic [KEY_BITS+VALUE_BITS-1:0]   ram_rdata;
   logic [KEY_BITS-1:0]              key_q;
   logic [VALUE_BITS-1:0]            value_q;

   logic          req_accept;
   logic          match;
   logic          scan_more;
   logic          iter_del_ok;
   logic [CW-1:0] iter_start;
   logic          out_free;
   state_type     start_state;

   lkv_slot_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(KEY_BITS + VALUE_BITS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign key_q   = ram_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
   assign value_q = ram_rdata[VALUE_BITS-1:0];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // shared compare: live key, and either any live key (iterator) or the searched key
   assign match = rd_pend_ff && (key_q != '0) &&
                  ((cmd_ff == CMD_ITER_NEXT) || (key_q == key_ff));
   assign scan_more = (scan_idx_ff < fill_ff);

   assign iter_start = iter_before_ff ? '0 :
                       (iter_pos_ff >= CAP_C) ? CAP_C : iter_pos_ff + 1'b1;
   assign iter_del_ok = !iter_before_ff && (iter_pos_ff < fill_ff);

   always_comb begin
      case (req_payload.command)
         CMD_SET: begin
            if (req_payload.value == '0 || req_payload.key == '0) begin
               start_state = S_DONE;
            end else begin
               start_state = S_SCAN;
            end
         end
         CMD_REMOVE, CMD_FIND: begin
            start_state = (req_payload.key == '0) ? S_DONE : S_SCAN;
         end
         CMD_ITER_NEXT: start_state = S_SCAN;
         CMD_ITER_DEL:  start_state = iter_del_ok ? S_POS_READ : S_DONE;
         default:       start_state = S_DONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = start_state;
            end
         end
         S_SCAN: begin
            if (match || !scan_more) begin
               state_in = S_DONE;
            end
         end
         S_POS_READ:  state_in = S_POS_CHECK;
         S_POS_CHECK: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      fill_in        = fill_ff;
      occ_in         = occ_ff;
      iter_pos_in    = iter_pos_ff;
      iter_before_in = iter_before_ff;
      scan_idx_in    = scan_idx_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = 1'b0;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_key_in     = res_key_ff;
      res_value_in   = res_value_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      ram_we         = 1'b0;
      ram_waddr      = fill_ff[AW-1:0];
      ram_wdata      = {key_ff, value_ff};
      ram_raddr      = scan_idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_payload.command;
               key_in        = req_payload.key;
               value_in      = req_payload.value;
               res_status_in = ST_OK;
               res_found_in  = 1'b0;
               res_key_in    = '0;
               res_value_in  = '0;
               scan_idx_in   = '0;
               case (req_payload.command)
                  CMD_SET: begin
                     if (req_payload.value == '0) begin
                        res_status_in = ST_ZERO_VALUE;
                     end else if (req_payload.key == '0) begin
                        res_status_in = ST_ZERO_KEY;
                     end
                  end
                  CMD_ITER_START: iter_before_in = 1'b1;
                  CMD_ITER_NEXT:  scan_idx_in = iter_start;
                  CMD_ITER_DEL: begin
                     if (!iter_del_ok) begin
                        res_status_in = ST_NO_ENTRY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (match) begin
               ram_waddr = rd_idx_ff[AW-1:0];
               case (cmd_ff)
                  CMD_SET: ram_we = 1'b1;
                  CMD_REMOVE: begin
                     ram_we       = 1'b1;
                     ram_wdata    = '0;
                     res_found_in = 1'b1;
                     if (occ_ff != '0) begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     res_found_in = 1'b1;
                     res_value_in = value_q;
                  end
                  CMD_ITER_NEXT: begin
                     res_found_in   = 1'b1;
                     res_key_in     = key_q;
                     res_value_in   = value_q;
                     iter_pos_in    = rd_idx_ff;
                     iter_before_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end else if (scan_more) begin
               rd_pend_in  = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               case (cmd_ff)
                  CMD_SET: begin
                     if (fill_ff >= CAP_C) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  // miss stops at the larger of start and fill mark
                  CMD_ITER_NEXT: begin
                     iter_pos_in    = scan_idx_ff;
                     iter_before_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POS_READ: begin
            ram_raddr = iter_pos_ff[AW-1:0];
         end
         S_POS_CHECK: begin
            if (key_q != '0) begin
               ram_we       = 1'b1;
               ram_waddr    = iter_pos_ff[AW-1:0];
               ram_wdata    = '0;
               res_found_in = 1'b1;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - 1'b1;
               end
            end else begin
               res_status_in = ST_NO_ENTRY;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = res_status_ff;
               rsp_in.found      = res_found_ff;
               rsp_in.out_key    = res_key_ff;
               rsp_in.out_value  = res_value_ff;
               rsp_in.live_count = COUNT_BITS'(occ_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         occ_ff         <= '0;
         iter_pos_ff    <= '0;
         iter_before_ff <= 1'b1;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         occ_ff         <= occ_in;
         iter_pos_ff    <= iter_pos_in;
         iter_before_ff <= iter_before_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_value_ff  <= res_value_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_occ_le_fill: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= fill_ff)
      else $error("live count above fill mark");

   a_fill_le_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_C)
      else $error("fill mark above capacity");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + 1'b1 ||
                         occ_ff == $past(occ_ff) - 1'b1))
      else $error("live count moved by more than one");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("sequencer idle right after accepting an item");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.status == ST_OK)
      else $error("found flagged with error status");

endmodule
